>>> rtl/pcsm_pkg.sv
// pcsm_pkg: sizes, instruction codes, fault and event codes, phase type
// for the p-code stack machine core; no dependencies
package pcsm_pkg;

    // sizes (PROGRAM_DEPTH is a power of two: counters wrap by truncation)
    localparam int STACK_DEPTH   = 512;
    localparam int PROGRAM_DEPTH = 1024;
    localparam int LEVEL_MAX     = 3;
    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int TOP_W = SP_W + 1;
    localparam int PC_W  = $clog2(PROGRAM_DEPTH);
    localparam int WORD_W = 32;

    // instruction functions
    localparam logic [2:0] F_LIT = 3'd0;
    localparam logic [2:0] F_OPR = 3'd1;
    localparam logic [2:0] F_LOD = 3'd2;
    localparam logic [2:0] F_STO = 3'd3;
    localparam logic [2:0] F_CAL = 3'd4;
    localparam logic [2:0] F_INT = 3'd5;
    localparam logic [2:0] F_JMP = 3'd6;
    localparam logic [2:0] F_JPC = 3'd7;

    // opr codes
    localparam logic [31:0] OPR_RET = 32'd0;
    localparam logic [31:0] OPR_NEG = 32'd1;
    localparam logic [31:0] OPR_ADD = 32'd2;
    localparam logic [31:0] OPR_SUB = 32'd3;
    localparam logic [31:0] OPR_MUL = 32'd4;
    localparam logic [31:0] OPR_DIV = 32'd5;
    localparam logic [31:0] OPR_ODD = 32'd6;
    localparam logic [31:0] OPR_EQL = 32'd8;
    localparam logic [31:0] OPR_NEQ = 32'd9;
    localparam logic [31:0] OPR_LSS = 32'd10;
    localparam logic [31:0] OPR_GEQ = 32'd11;
    localparam logic [31:0] OPR_GTR = 32'd12;
    localparam logic [31:0] OPR_LEQ = 32'd13;
    localparam logic [31:0] OPR_PRN = 32'd14;
    localparam logic [31:0] OPR_NLN = 32'd15;
    localparam logic [31:0] OPR_RED = 32'd16;

    // fault codes
    localparam logic [1:0] FLT_NONE  = 2'd0;
    localparam logic [1:0] FLT_OVER  = 2'd1;
    localparam logic [1:0] FLT_INDEX = 2'd2;
    localparam logic [1:0] FLT_DIV   = 2'd3;

    // event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_PRINT = 2'd1;
    localparam logic [1:0] EV_NEWLN = 2'd2;
    localparam logic [1:0] EV_READ  = 2'd3;

    // what a pending stack read is for
    typedef enum logic [2:0] {
        PH_WALK = 3'd0,
        PH_RET1 = 3'd1,
        PH_RET2 = 3'd2,
        PH_UN   = 3'd3,
        PH_X    = 3'd4,
        PH_Y    = 3'd5,
        PH_PRT  = 3'd6,
        PH_MEM  = 3'd7
    } t_phase;

endpackage

>>> rtl/pcsm_ram.sv
// pcsm_ram: generic single write port, single read port ram, registered read
// no dependencies
module pcsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pcode_stack_machine_core_unit.sv
// pcode_stack_machine_core_unit: executes one p-code instruction per item
// depends on pcsm_pkg and pcsm_ram (the data stack)
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+--------------------------------------------
//  input   | i_valid | o_ready | i_func i_level i_arg i_read_value
//  output  | o_valid | i_ready | o_next_pc o_halted o_event_kind o_out_value
//          |         |         | o_fault
//
// An item's duration depends on its stack traffic, set by the stack ram's registered
// read: each stack read passes S_READ then S_USE, each write passes S_WRITE, and
// the static-link walk makes up to LEVEL_MAX reads. Divide adds the bit-serial divider.
// Reset is synchronous; no clearing pass, the three low stack words read as
// zero until written. A stalled output holds the finished result and the
// sequencer waits in its done state; the input is taken only when idle.
module pcode_stack_machine_core_unit
    import pcsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_func,
    input  logic [1:0]        i_level,
    input  logic signed [31:0] i_arg,
    input  logic signed [31:0] i_read_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [9:0]        o_next_pc,
    output logic              o_halted,
    output logic [1:0]        o_event_kind,
    output logic signed [31:0] o_out_value,
    output logic [1:0]        o_fault
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EXEC  = 8'b0000_0010,
        S_LINK  = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_USE   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_CALL  = 8'b1000_0000
    } t_state;

    localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(STACK_DEPTH);
    localparam logic [1:0] LV_SAT = 2'(LEVEL_MAX);

    t_state r_state, n_state;
    logic   r_done, n_done;
    t_phase r_phase, n_phase;
    logic [2:0]        r_func, n_func;
    logic [1:0]        r_lv, n_lv;
    logic [31:0]       r_arg, n_arg;
    logic [31:0]       r_rv, n_rv;
    logic [TOP_W-1:0]  r_t, n_t;
    logic [SP_W-1:0]   r_b, n_b;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic              r_stop, n_stop;
    logic [2:0]        r_v, n_v;
    logic [SP_W-1:0]   r_raddr, n_raddr;
    logic [SP_W-1:0]   r_waddr, n_waddr;
    logic [31:0]       r_x, n_x;
    logic [31:0]       r_res, n_res;
    logic [1:0]        r_ccnt, n_ccnt;
    logic [PC_W-1:0]   r_np, n_np;
    logic [1:0]        r_ev, n_ev;
    logic [31:0]       r_ov, n_ov;
    logic [1:0]        r_flt, n_flt;
    logic [31:0]       r_quo, n_quo;
    logic [31:0]       r_rem, n_rem;
    logic [31:0]       r_dvs, n_dvs;
    logic [4:0]        r_dcnt, n_dcnt;
    logic              r_qneg, n_qneg;
    logic              r_o_valid, n_o_valid;
    logic [PC_W-1:0]   r_o_pc, n_o_pc;
    logic              r_o_halt, n_o_halt;
    logic [1:0]        r_o_ev, n_o_ev;
    logic [31:0]       r_o_val, n_o_val;
    logic [1:0]        r_o_flt, n_o_flt;

    logic              w_we;
    logic [SP_W-1:0]   w_waddr;
    logic [31:0]       w_wdata;
    logic [31:0]       w_ram_q;
    logic [31:0]       w_rd;
    logic [PC_W-1:0]   w_np_seq;
    logic [PC_W-1:0]   w_tgt;
    logic signed [33:0] w_na_mem;
    logic signed [33:0] w_na_int;
    logic [32:0]       w_dshift;
    logic [32:0]       w_ddiff;
    logic [31:0]       w_prod;
    logic              w_out_load;

    // data stack
    pcsm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_raddr),
        .o_rdata (w_ram_q)
    );

    // low words read as zero until written
    assign w_rd = (r_raddr < SP_W'(3) && !r_v[r_raddr[1:0]]) ? 32'd0 : w_ram_q;

    assign w_np_seq = (r_pc == PC_W'(PROGRAM_DEPTH - 1)) ? '0 : r_pc + PC_W'(1);
    assign w_tgt    = r_arg[PC_W-1:0];
    assign w_na_mem = $signed({2'b00, r_x}) + $signed({{2{r_arg[31]}}, r_arg});
    assign w_na_int = $signed({{(34-TOP_W){1'b0}}, r_t}) + $signed({{2{r_arg[31]}}, r_arg});
    assign w_prod   = r_x * w_rd;

    // divider step
    assign w_dshift = {r_rem, r_quo[31]};
    assign w_ddiff  = w_dshift - {1'b0, r_dvs};

    assign w_out_load = !r_o_valid || i_ready;

    assign o_ready = (r_state == S_IDLE) && !r_done;

    // sequencer
    always_comb begin
        n_state = r_state;  n_done = r_done;   n_phase = r_phase;
        n_func = r_func;    n_lv = r_lv;       n_arg = r_arg;     n_rv = r_rv;
        n_t = r_t;          n_b = r_b;         n_pc = r_pc;       n_stop = r_stop;
        n_v = r_v;          n_raddr = r_raddr; n_waddr = r_waddr;
        n_x = r_x;          n_res = r_res;     n_ccnt = r_ccnt;
        n_np = r_np;        n_ev = r_ev;       n_ov = r_ov;       n_flt = r_flt;
        n_quo = r_quo;      n_rem = r_rem;     n_dvs = r_dvs;
        n_dcnt = r_dcnt;    n_qneg = r_qneg;
        n_o_valid = r_o_valid; n_o_pc = r_o_pc; n_o_halt = r_o_halt;
        n_o_ev = r_o_ev;    n_o_val = r_o_val; n_o_flt = r_o_flt;
        w_we = 1'b0;        w_waddr = r_waddr; w_wdata = r_res;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            // emit a finished result, or take an item
            S_IDLE: begin
                if (r_done) begin
                    if (w_out_load) begin
                        n_o_valid = 1'b1;
                        n_done = 1'b0;
                        if (r_stop) begin
                            n_o_pc = r_pc;  n_o_halt = 1'b1;
                            n_o_ev = EV_NONE; n_o_val = '0; n_o_flt = FLT_NONE;
                        end else if (r_flt != FLT_NONE) begin
                            n_o_pc = r_pc;  n_o_halt = 1'b1;
                            n_o_ev = EV_NONE; n_o_val = '0; n_o_flt = r_flt;
                            n_stop = 1'b1;
                        end else begin
                            n_o_pc = r_np;  n_o_halt = (r_np == '0);
                            n_o_ev = r_ev;  n_o_val = r_ov; n_o_flt = FLT_NONE;
                            n_pc = r_np;
                            n_stop = (r_np == '0);
                        end
                    end
                end else if (i_valid) begin
                    n_func = i_func;
                    n_lv = (i_level > LV_SAT) ? LV_SAT : i_level;
                    n_arg = i_arg;
                    n_rv = i_read_value;
                    n_state = r_stop ? S_IDLE : S_EXEC;
                    n_done = r_stop;
                end
            end

            // decode and check
            S_EXEC: begin
                n_np = w_np_seq; n_ev = EV_NONE; n_ov = '0; n_flt = FLT_NONE;
                n_state = S_IDLE; n_done = 1'b1;
                case (r_func)
                    F_LIT: begin
                        if (r_t >= TOP_FULL) begin
                            n_flt = FLT_OVER;
                        end else begin
                            n_waddr = r_t[SP_W-1:0]; n_res = r_arg;
                            n_t = r_t + TOP_W'(1);
                            n_state = S_WRITE; n_done = 1'b0;
                        end
                    end
                    F_OPR: begin
                        if (r_arg == OPR_RET) begin
                            if ({1'b0, r_b} + TOP_W'(2) >= TOP_FULL) begin
                                n_flt = FLT_INDEX;
                            end else begin
                                n_raddr = r_b + SP_W'(1); n_phase = PH_RET1;
                                n_state = S_READ; n_done = 1'b0;
                            end
                        end else if (r_arg == OPR_NEG || r_arg == OPR_ODD
                                     || r_arg == OPR_PRN) begin
                            if (r_t < TOP_W'(1) || r_t > TOP_FULL) begin
                                n_flt = FLT_INDEX;
                            end else begin
                                n_raddr = SP_W'(r_t - TOP_W'(1));
                                n_phase = (r_arg == OPR_PRN) ? PH_PRT : PH_UN;
                                n_state = S_READ; n_done = 1'b0;
                            end
                        end else if ((r_arg >= OPR_ADD && r_arg <= OPR_DIV)
                                     || (r_arg >= OPR_EQL && r_arg <= OPR_LEQ)) begin
                            if (r_t < TOP_W'(2) || r_t > TOP_FULL) begin
                                n_flt = FLT_INDEX;
                            end else begin
                                n_raddr = SP_W'(r_t - TOP_W'(2)); n_phase = PH_X;
                                n_state = S_READ; n_done = 1'b0;
                            end
                        end else if (r_arg == OPR_NLN) begin
                            n_ev = EV_NEWLN;
                        end else if (r_arg == OPR_RED) begin
                            if (r_t >= TOP_FULL) begin
                                n_flt = FLT_OVER;
                            end else begin
                                n_waddr = r_t[SP_W-1:0]; n_res = r_rv;
                                n_t = r_t + TOP_W'(1);
                                n_ev = EV_READ; n_ov = r_rv;
                                n_state = S_WRITE; n_done = 1'b0;
                            end
                        end
                    end
                    F_LOD, F_STO, F_CAL: begin
                        n_x = {{(32-SP_W){1'b0}}, r_b};
                        n_state = S_LINK; n_done = 1'b0;
                    end
                    F_INT: begin
                        if (w_na_int > $signed(34'(STACK_DEPTH))) begin
                            n_flt = FLT_OVER;
                        end else if (w_na_int < 0) begin
                            n_flt = FLT_INDEX;
                        end else begin
                            n_t = w_na_int[TOP_W-1:0];
                        end
                    end
                    F_JMP: begin
                        n_np = w_tgt;
                    end
                    F_JPC: begin
                        if (r_t < TOP_W'(1) || r_t > TOP_FULL) begin
                            n_flt = FLT_INDEX;
                        end else begin
                            n_raddr = SP_W'(r_t - TOP_W'(1)); n_phase = PH_UN;
                            n_state = S_READ; n_done = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end

            // static-link walk, then address checks
            S_LINK: begin
                if (r_x >= 32'(STACK_DEPTH)) begin
                    n_flt = FLT_INDEX; n_state = S_IDLE; n_done = 1'b1;
                end else if (r_lv != 2'd0) begin
                    n_raddr = r_x[SP_W-1:0]; n_phase = PH_WALK; n_state = S_READ;
                end else if (r_func == F_CAL) begin
                    if (r_t + TOP_W'(2) >= TOP_FULL) begin
                        n_flt = FLT_OVER; n_state = S_IDLE; n_done = 1'b1;
                    end else begin
                        n_ccnt = 2'd0; n_state = S_CALL;
                    end
                end else if (w_na_mem < 0 || w_na_mem >= $signed(34'(STACK_DEPTH))) begin
                    n_flt = FLT_INDEX; n_state = S_IDLE; n_done = 1'b1;
                end else if (r_func == F_LOD) begin
                    if (r_t >= TOP_FULL) begin
                        n_flt = FLT_OVER; n_state = S_IDLE; n_done = 1'b1;
                    end else begin
                        n_raddr = w_na_mem[SP_W-1:0]; n_waddr = r_t[SP_W-1:0];
                        n_t = r_t + TOP_W'(1);
                        n_phase = PH_MEM; n_state = S_READ;
                    end
                end else begin
                    if (r_t < TOP_W'(1) || r_t > TOP_FULL) begin
                        n_flt = FLT_INDEX; n_state = S_IDLE; n_done = 1'b1;
                    end else begin
                        n_raddr = SP_W'(r_t - TOP_W'(1)); n_waddr = w_na_mem[SP_W-1:0];
                        n_t = r_t - TOP_W'(1);
                        n_phase = PH_MEM; n_state = S_READ;
                    end
                end
            end

            // ram reads the registered address
            S_READ: begin
                n_state = S_USE;
            end

            // consume read data
            S_USE: begin
                n_state = S_IDLE; n_done = 1'b1;
                case (r_phase)
                    PH_WALK: begin
                        n_x = w_rd; n_lv = r_lv - 2'd1;
                        n_state = S_LINK; n_done = 1'b0;
                    end
                    PH_RET1: begin
                        if (w_rd >= 32'(STACK_DEPTH)) begin
                            n_flt = FLT_INDEX;
                        end else begin
                            n_x = w_rd; n_raddr = r_b + SP_W'(2); n_phase = PH_RET2;
                            n_state = S_READ; n_done = 1'b0;
                        end
                    end
                    PH_RET2: begin
                        n_np = w_rd[PC_W-1:0];
                        n_t = {1'b0, r_b};
                        n_b = r_x[SP_W-1:0];
                    end
                    PH_UN: begin
                        if (r_func == F_JPC) begin
                            if (w_rd == '0) begin
                                n_np = w_tgt;
                            end
                            n_t = r_t - TOP_W'(1);
                        end else begin
                            n_res = (r_arg == OPR_NEG) ? (32'd0 - w_rd) : {31'd0, w_rd[0]};
                            n_waddr = r_raddr;
                            n_state = S_WRITE; n_done = 1'b0;
                        end
                    end
                    PH_X: begin
                        n_x = w_rd; n_raddr = r_raddr + SP_W'(1); n_phase = PH_Y;
                        n_state = S_READ; n_done = 1'b0;
                    end
                    PH_Y: begin
                        n_waddr = r_raddr - SP_W'(1);
                        n_t = r_t - TOP_W'(1);
                        n_state = S_WRITE; n_done = 1'b0;
                        if (r_arg == OPR_ADD) begin
                            n_res = r_x + w_rd;
                        end else if (r_arg == OPR_SUB) begin
                            n_res = r_x - w_rd;
                        end else if (r_arg == OPR_MUL) begin
                            n_res = w_prod;
                        end else if (r_arg == OPR_DIV) begin
                            if (w_rd == '0) begin
                                n_flt = FLT_DIV; n_t = r_t;
                                n_state = S_IDLE; n_done = 1'b1;
                            end else begin
                                n_quo = r_x[31] ? (32'd0 - r_x) : r_x;
                                n_dvs = w_rd[31] ? (32'd0 - w_rd) : w_rd;
                                n_rem = '0; n_dcnt = '0;
                                n_qneg = r_x[31] ^ w_rd[31];
                                n_state = S_DIV;
                            end
                        end else if (r_arg == OPR_EQL) begin
                            n_res = {31'd0, r_x == w_rd};
                        end else if (r_arg == OPR_NEQ) begin
                            n_res = {31'd0, r_x != w_rd};
                        end else if (r_arg == OPR_LSS) begin
                            n_res = {31'd0, $signed(r_x) < $signed(w_rd)};
                        end else if (r_arg == OPR_GEQ) begin
                            n_res = {31'd0, $signed(r_x) >= $signed(w_rd)};
                        end else if (r_arg == OPR_GTR) begin
                            n_res = {31'd0, $signed(r_x) > $signed(w_rd)};
                        end else begin
                            n_res = {31'd0, $signed(r_x) <= $signed(w_rd)};
                        end
                    end
                    PH_PRT: begin
                        n_ev = EV_PRINT; n_ov = w_rd;
                        n_t = r_t - TOP_W'(1);
                    end
                    PH_MEM: begin
                        n_res = w_rd;
                        n_state = S_WRITE; n_done = 1'b0;
                    end
                    default: ;
                endcase
            end

            // restoring divide, one quotient bit a cycle
            S_DIV: begin
                if (!w_ddiff[32]) begin
                    n_rem = w_ddiff[31:0];
                end else begin
                    n_rem = w_dshift[31:0];
                end
                n_quo = {r_quo[30:0], !w_ddiff[32]};
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd31) begin
                    n_res = r_qneg ? (32'd0 - n_quo) : n_quo;
                    n_state = S_WRITE;
                end
            end

            // single stack write
            S_WRITE: begin
                w_we = 1'b1;
                if (r_waddr < SP_W'(3)) begin
                    n_v[r_waddr[1:0]] = 1'b1;
                end
                n_state = S_IDLE; n_done = 1'b1;
            end

            // call frame: static link, dynamic link, return address
            S_CALL: begin
                w_we = 1'b1;
                w_waddr = SP_W'(r_t + TOP_W'(r_ccnt));
                case (r_ccnt)
                    2'd0:    w_wdata = r_x;
                    2'd1:    w_wdata = {{(32-SP_W){1'b0}}, r_b};
                    default: w_wdata = {{(32-PC_W){1'b0}}, w_np_seq};
                endcase
                if (w_waddr < SP_W'(3)) begin
                    n_v[w_waddr[1:0]] = 1'b1;
                end
                n_ccnt = r_ccnt + 2'd1;
                if (r_ccnt == 2'd2) begin
                    n_b = r_t[SP_W-1:0];
                    n_np = w_tgt;
                    n_state = S_IDLE; n_done = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_t       <= '0;
            r_b       <= '0;
            r_pc      <= '0;
            r_stop    <= 1'b0;
            r_v       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_t       <= n_t;
            r_b       <= n_b;
            r_pc      <= n_pc;
            r_stop    <= n_stop;
            r_v       <= n_v;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;  r_func <= n_func;   r_lv <= n_lv;
        r_arg <= n_arg;      r_rv <= n_rv;       r_raddr <= n_raddr;
        r_waddr <= n_waddr;  r_x <= n_x;         r_res <= n_res;
        r_ccnt <= n_ccnt;    r_np <= n_np;       r_ev <= n_ev;
        r_ov <= n_ov;        r_flt <= n_flt;     r_quo <= n_quo;
        r_rem <= n_rem;      r_dvs <= n_dvs;     r_dcnt <= n_dcnt;
        r_qneg <= n_qneg;    r_o_pc <= n_o_pc;   r_o_halt <= n_o_halt;
        r_o_ev <= n_o_ev;    r_o_val <= n_o_val; r_o_flt <= n_o_flt;
    end

    assign o_valid      = r_o_valid;
    assign o_next_pc    = 10'(r_o_pc);
    assign o_halted     = r_o_halt;
    assign o_event_kind = r_o_ev;
    assign o_out_value  = r_o_val;
    assign o_fault      = r_o_flt;

endmodule

>>> tb/sv/testbench.sv
// testbench for pcode_stack_machine_core_unit: runs p-code items through the
// core and checks every result against an in-bench model of the machine
// depends on pcsm_pkg and the core rtl
module testbench;
    import pcsm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]  func;
        logic [1:0]  level;
        logic [31:0] arg;
        logic [31:0] rval;
    } t_instr;

    typedef struct {
        logic [9:0]  npc;
        logic        halted;
        logic [1:0]  ev;
        logic [31:0] val;
        logic [1:0]  flt;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [2:0]  i_func = '0;
    logic [1:0]  i_level = '0;
    logic [31:0] i_arg = '0;
    logic [31:0] i_read_value = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [9:0]  o_next_pc;
    logic        o_halted;
    logic [1:0]  o_event_kind;
    logic [31:0] o_out_value;
    logic [1:0]  o_fault;

    // machine model state
    logic [31:0] mstack [STACK_DEPTH];
    bit          mwritten [STACK_DEPTH];
    int          mtop, mbase, mpc;
    bit          mstopped;
    bit          touch_bad;

    t_outcome    expected_q [$];
    int          errors = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          hold_left = 0;
    bit          quiet = 1'b0;

    pcode_stack_machine_core_unit dut (.*);

    always #4 i_clk = ~i_clk;

    // read a stack word, flagging a read of a word above the three low ones never written
    function automatic logic [31:0] stack_rd(longint idx);
        if (idx > 2 && !mwritten[idx]) touch_bad = 1'b1;
        return mstack[idx];
    endfunction

    // one instruction; state changes only when commit is set
    function automatic void machine_step(input t_instr it, input bit commit,
                                         output t_outcome r, output bit bad);
        longint   t, b, np, tgt, nt, nb, na;
        logic [1:0]  flt, ev;
        logic [31:0] ov, x, y, rr;
        int       wn, lv;
        longint   wi [3];
        logic [31:0] wv [3];
        touch_bad = 1'b0;
        bad = 1'b0;
        if (mstopped) begin
            r = '{mpc[9:0], 1'b1, EV_NONE, 32'd0, FLT_NONE};
            return;
        end
        t = mtop; nt = t; nb = mbase;
        np = (mpc + 1) % PROGRAM_DEPTH;
        tgt = it.arg % PROGRAM_DEPTH;
        flt = FLT_NONE; ev = EV_NONE; ov = '0; wn = 0;
        lv = it.level;
        case (it.func)
            F_LIT: begin
                if (t >= STACK_DEPTH) flt = FLT_OVER;
                else begin
                    wi[0] = t; wv[0] = it.arg; wn = 1; nt = t + 1;
                end
            end
            F_OPR: begin
                if (it.arg == OPR_RET) begin
                    b = mbase;
                    if (b + 2 >= STACK_DEPTH) flt = FLT_INDEX;
                    else begin
                        x = stack_rd(b + 1);
                        if (x >= STACK_DEPTH) flt = FLT_INDEX;
                        else begin
                            np = stack_rd(b + 2) % PROGRAM_DEPTH;
                            nb = x; nt = b;
                        end
                    end
                end else if (it.arg == OPR_NEG || it.arg == OPR_ODD) begin
                    if (t < 1) flt = FLT_INDEX;
                    else begin
                        x = stack_rd(t - 1);
                        wi[0] = t - 1; wn = 1;
                        wv[0] = (it.arg == OPR_NEG) ? -x : {31'd0, x[0]};
                    end
                end else if ((it.arg >= OPR_ADD && it.arg <= OPR_DIV) ||
                             (it.arg >= OPR_EQL && it.arg <= OPR_LEQ)) begin
                    if (t < 2) flt = FLT_INDEX;
                    else begin
                        x = stack_rd(t - 2);
                        y = stack_rd(t - 1);
                        rr = '0;
                        case (it.arg)
                            OPR_ADD: rr = x + y;
                            OPR_SUB: rr = x - y;
                            OPR_MUL: rr = x * y;
                            OPR_DIV: begin
                                if (y == 0) flt = FLT_DIV;
                                else if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) rr = x;
                                else rr = $signed(x) / $signed(y);
                            end
                            OPR_EQL: rr = {31'd0, x == y};
                            OPR_NEQ: rr = {31'd0, x != y};
                            OPR_LSS: rr = {31'd0, $signed(x) < $signed(y)};
                            OPR_GEQ: rr = {31'd0, $signed(x) >= $signed(y)};
                            OPR_GTR: rr = {31'd0, $signed(x) > $signed(y)};
                            default: rr = {31'd0, $signed(x) <= $signed(y)};
                        endcase
                        wi[0] = t - 2; wv[0] = rr; wn = 1; nt = t - 1;
                    end
                end else if (it.arg == OPR_PRN) begin
                    if (t < 1) flt = FLT_INDEX;
                    else begin
                        ev = EV_PRINT; ov = stack_rd(t - 1); nt = t - 1;
                    end
                end else if (it.arg == OPR_NLN) begin
                    ev = EV_NEWLN;
                end else if (it.arg == OPR_RED) begin
                    if (t >= STACK_DEPTH) flt = FLT_OVER;
                    else begin
                        wi[0] = t; wv[0] = it.rval; wn = 1; nt = t + 1;
                        ev = EV_READ; ov = it.rval;
                    end
                end
            end
            F_LOD, F_STO, F_CAL: begin
                // static-link walk
                b = mbase;
                for (int k = 0; k < lv; k++) begin
                    if (flt == FLT_NONE) begin
                        if (b >= STACK_DEPTH) flt = FLT_INDEX;
                        else b = stack_rd(b);
                    end
                end
                if (flt == FLT_NONE && b >= STACK_DEPTH) flt = FLT_INDEX;
                if (flt == FLT_NONE && it.func == F_CAL) begin
                    if (t + 2 >= STACK_DEPTH) flt = FLT_OVER;
                    else begin
                        wi[0] = t; wv[0] = 32'(b);
                        wi[1] = t + 1; wv[1] = mbase;
                        wi[2] = t + 2; wv[2] = 32'(np);
                        wn = 3; nb = t; np = tgt;
                    end
                end else if (flt == FLT_NONE) begin
                    na = b + longint'($signed(it.arg));
                    if (na < 0 || na >= STACK_DEPTH) flt = FLT_INDEX;
                    else if (it.func == F_LOD) begin
                        if (t >= STACK_DEPTH) flt = FLT_OVER;
                        else begin
                            wi[0] = t; wv[0] = stack_rd(na); wn = 1; nt = t + 1;
                        end
                    end else begin
                        if (t < 1) flt = FLT_INDEX;
                        else begin
                            wi[0] = na; wv[0] = stack_rd(t - 1); wn = 1; nt = t - 1;
                        end
                    end
                end
            end
            F_INT: begin
                na = t + longint'($signed(it.arg));
                if (na > STACK_DEPTH) flt = FLT_OVER;
                else if (na < 0) flt = FLT_INDEX;
                else nt = na;
            end
            F_JMP: np = tgt;
            default: begin
                if (t < 1) flt = FLT_INDEX;
                else begin
                    if (stack_rd(t - 1) == 0) np = tgt;
                    nt = t - 1;
                end
            end
        endcase
        bad = touch_bad;
        if (flt != FLT_NONE) begin
            r = '{mpc[9:0], 1'b1, EV_NONE, 32'd0, flt};
            if (commit) mstopped = 1'b1;
            return;
        end
        r = '{np[9:0], np == 0, ev, ov, FLT_NONE};
        if (commit) begin
            for (int k = 0; k < wn; k++) begin
                mstack[wi[k]] = wv[k];
                mwritten[wi[k]] = 1'b1;
            end
            mtop = int'(nt); mbase = int'(nb); mpc = int'(np);
            mstopped = (np == 0);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 32'd0, 32'd0);
            end else begin
                e = expected_q.pop_front();
                if (o_next_pc !== e.npc) report_mismatch("next_pc", o_next_pc, e.npc);
                if (o_halted !== e.halted) report_mismatch("halted", o_halted, e.halted);
                if (o_event_kind !== e.ev) report_mismatch("event_kind", o_event_kind, e.ev);
                if (o_out_value !== e.val) report_mismatch("out_value", o_out_value, e.val);
                if (o_fault !== e.flt) report_mismatch("fault", o_fault, e.flt);
            end
            results_seen++;
        end
    end

    // receiver: random stalls, long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (quiet) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // offer one item, wait for acceptance, then predict its result
    // valid stays high after acceptance; the next item or an idle drops it
    task automatic send_item(input t_instr it);
        t_outcome r;
        bit bad;
        if (!quiet && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= it.func;
        i_level <= it.level;
        i_arg <= it.arg;
        i_read_value <= it.rval;
        do @(posedge i_clk); while (!o_ready);
        machine_step(it, 1'b1, r, bad);
        expected_q.push_back(r);
        items_sent++;
    endtask

    // send only if the item stays within written stack words
    task automatic send_if_clean(input t_instr it);
        t_outcome r;
        bit bad;
        machine_step(it, 1'b0, r, bad);
        if (!bad) send_item(it);
    endtask

    function automatic t_instr random_instr();
        t_instr it;
        int sel;
        sel = $urandom_range(0, 15);
        it.level = 2'($urandom_range(0, 3));
        it.rval = $urandom;
        case (sel)
            0, 1, 2, 3: begin
                it.func = F_LIT;
                case ($urandom_range(0, 5))
                    0: it.arg = 32'h8000_0000;
                    1: it.arg = 32'h7FFF_FFFF;
                    2: it.arg = $urandom_range(0, 3);
                    default: it.arg = $urandom;
                endcase
            end
            4, 5, 6, 7: begin
                it.func = F_OPR;
                it.arg = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 17);
            end
            8: begin
                it.func = F_LOD; it.arg = $urandom_range(0, 16) - 4;
            end
            9: begin
                it.func = F_STO; it.arg = $urandom_range(0, 16) - 4;
            end
            10: begin
                it.func = F_CAL; it.arg = $urandom_range(1, 1023);
            end
            11: begin
                it.func = F_INT; it.arg = $urandom_range(0, 8) - 3;
            end
            12: begin
                it.func = F_JMP;
                it.arg = {22'($urandom_range(0, 4194303)), 10'($urandom_range(1, 1023))};
            end
            default: begin
                it.func = F_JPC; it.arg = $urandom_range(1, 1023);
            end
        endcase
        return it;
    endfunction

    // pick an item that neither faults, halts nor reads an unwritten word
    task automatic send_running_item();
        t_instr it;
        t_outcome r;
        bit bad;
        bit found;
        found = 1'b0;
        for (int k = 0; k < 64 && !found; k++) begin
            it = random_instr();
            machine_step(it, 1'b0, r, bad);
            if (!bad && r.flt == FLT_NONE && !r.halted) found = 1'b1;
        end
        if (!found) begin
            it = '{F_JMP, 2'd0, 32'($urandom_range(1, 1023)), 32'd0};
        end
        send_item(it);
    endtask

    task automatic test_reset();
        mtop = 0; mbase = 0; mpc = 0; mstopped = 1'b0;
        for (int k = 0; k < STACK_DEPTH; k++) begin
            mstack[k] = '0;
            mwritten[k] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // edges of arithmetic, several opr codes, memory and control flow
    task automatic test_directed();
        send_if_clean('{F_LIT, 2'd0, 32'h8000_0000, 32'd0});
        send_if_clean('{F_LIT, 2'd3, 32'hFFFF_FFFF, 32'd0});
        send_if_clean('{F_OPR, 2'd0, OPR_DIV, 32'd0});
        send_if_clean('{F_OPR, 2'd0, OPR_PRN, 32'd0});
        send_if_clean('{F_LIT, 2'd0, 32'd7, 32'd0});
        send_if_clean('{F_LIT, 2'd0, 32'hFFFF_FFFE, 32'd0});
        send_if_clean('{F_OPR, 2'd0, OPR_DIV, 32'd0});
        send_if_clean('{F_OPR, 2'd0, OPR_ODD, 32'd0});
        send_if_clean('{F_OPR, 2'd0, OPR_NEG, 32'd0});
        send_if_clean('{F_LIT, 2'd0, 32'd5, 32'd0});
        send_if_clean('{F_OPR, 2'd0, OPR_LSS, 32'd0});
        send_if_clean('{F_OPR, 2'd0, OPR_NLN, 32'hFFFF_FFFF});
        send_if_clean('{F_OPR, 2'd0, OPR_RED, 32'h7FFF_FFFF});
        send_if_clean('{F_OPR, 2'd0, 32'd7, 32'd0});
        send_if_clean('{F_OPR, 2'd0, OPR_MUL, 32'h8000_0000});
        send_if_clean('{F_STO, 2'd0, 32'd0, 32'd0});
        send_if_clean('{F_LOD, 2'd0, 32'd0, 32'd0});
        send_if_clean('{F_LIT, 2'd0, 32'd0, 32'd0});
        send_if_clean('{F_JPC, 2'd0, 32'd40, 32'd0});
        send_if_clean('{F_CAL, 2'd0, 32'hFFFF_FC64, 32'd0});
        send_if_clean('{F_INT, 2'd0, 32'd3, 32'd0});
        send_if_clean('{F_LIT, 2'd0, 32'd9, 32'd0});
        send_if_clean('{F_OPR, 2'd0, OPR_GEQ, 32'd0});
        send_if_clean('{F_OPR, 2'd0, OPR_RET, 32'd0});
        send_if_clean('{F_JMP, 2'd0, 32'd200, 32'd0});
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            quiet = (n >= count / 2 && n < count / 2 + 150);
            send_running_item();
        end
        quiet = 1'b0;
    endtask

    // receiver holds off while items keep coming
    task automatic test_backpressure();
        hold_left <= 400;
        for (int n = 0; n < 30; n++) send_running_item();
    endtask

    // end the program with a fault or a normal halt, then send ignored items
    task automatic test_halt();
        t_instr it;
        int sel;
        sel = $urandom_range(0, 3);
        case (sel)
            0: it = '{F_JMP, 2'd0, 32'd0, 32'd0};
            1: it = '{F_INT, 2'd0, 32'(-(mtop + 1)), 32'd0};
            2: it = '{F_INT, 2'd0, 32'(STACK_DEPTH + 1 - mtop), 32'd0};
            default: begin
                if (mtop < STACK_DEPTH - 2) begin
                    send_item('{F_LIT, 2'd0, 32'd5, 32'd0});
                    send_item('{F_LIT, 2'd0, 32'd0, 32'd0});
                    it = '{F_OPR, 2'd0, OPR_DIV, 32'd0};
                end else begin
                    it = '{F_JMP, 2'd0, 32'd0, 32'd0};
                end
            end
        endcase
        send_item(it);
        for (int n = 0; n < 6; n++) send_item(random_instr());
    endtask

    initial begin
        int guard;
        test_reset();
        test_directed();
        test_random(900);
        test_backpressure();
        test_random(950);
        test_halt();
        i_valid <= 1'b0;
        guard = 0;
        while (expected_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
        $display("ran %0d instructions, %0d results checked, incl. arithmetic edges,",
                 items_sent, results_seen);
        $display("calls and returns, a long output stall and a final halt");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
